// File: src/bca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bca_pkg;

	localparam int MAX_CLUSTERS  = 65536;
	localparam int CLUSTER_BYTES = 2048;
	localparam int MAX_BATCH     = 64;

	localparam int WORD_BITS = 64;
	localparam int MAP_WORDS = (MAX_CLUSTERS + WORD_BITS - 1) / WORD_BITS;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int WADDR_W   = $clog2(MAP_WORDS);
	localparam int PER_BLOCK = CLUSTER_BYTES * 8;

	localparam int CL_W    = 16;
	localparam int FC_W    = 17;
	localparam int TOT_W   = 17;
	localparam int START_W = 16;
	localparam int CNT_W   = 7;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd1;

	localparam logic [1:0] MODE_ALLOC  = 2'd0;
	localparam logic [1:0] MODE_FREE   = 2'd1;
	localparam logic [1:0] MODE_FORMAT = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	typedef struct packed {
		logic [1:0]       mode;
		logic [CL_W-1:0]  hint;
		logic [CNT_W-1:0] count;
		logic [CL_W-1:0]  cluster_to_free;
	} req_t;

	typedef struct packed {
		logic [CL_W-1:0] cluster;
		logic [1:0]      status;
		logic            last;
		logic [FC_W-1:0] free_count;
	} res_t;

endpackage

`default_nettype wire

// File: src/bca_ffs.sv
`timescale 1ns / 1ps
`default_nettype none

module bca_ffs (
	input  logic [bca_pkg::WORD_BITS-1:0] vec,
	output logic [bca_pkg::BIT_W-1:0]     idx
);
	import bca_pkg::*;

	logic [WORD_BITS-1:0] iso;

	// isolate the lowest set bit, then encode it
	assign iso = vec & (~vec + WORD_BITS'(1));

	always_comb begin
		idx = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			if (iso[b]) begin
				idx = idx | BIT_W'(b);
			end
		end
	end

endmodule

`default_nettype wire

// File: src/bitmap_cluster_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Next-fit cluster allocator over a free bitmap held in a 1024 x 64 RAM.
// Commands: an item is taken on a rising edge with start high and busy low;
// mode selects allocate, free or format. Results appear on res for one cycle
// each, marked by res_strobe, and cannot be held off by the receiver.
// Registers are written on cfg (valid/ready, ready always high) while idle, a
// rule for the user that the block does not enforce. After reset it sweeps the
// 1024 RAM words to zero with busy high; cfg writes are taken during the sweep.
// Flow, one RAM port pair with a registered read sets the pace:
//   rejected requests: one result on the cycle after acceptance, no busy time
//   free: the word is read, then written back; the result follows the write
//   format: busy, one word written a cycle, result after the last word
//   allocate: a scan step per bitmap word, a pick step per cluster taken, a
//   write-back and read step per word that yields clusters, and a finish step.
// Allocation results follow one a cycle while a word is being taken from; the
// last is marked, and a fruitless search gives one no-space result.
module bitmap_cluster_allocator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  bca_pkg::req_t                    req,
	output logic                             res_strobe,
	output bca_pkg::res_t                    res,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bca_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bca_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import bca_pkg::*;

	typedef enum logic [8:0] {
		S_CLR  = 9'b000000001,
		S_IDLE = 9'b000000010,
		S_SCAN = 9'b000000100,
		S_PICK = 9'b000001000,
		S_WB   = 9'b000010000,
		S_RD   = 9'b000100000,
		S_FIN  = 9'b001000000,
		S_FREE = 9'b010000000,
		S_FMT  = 9'b100000000
	} state_t;

	state_t state_q;

	logic [TOT_W-1:0]   total_q;
	logic [START_W-1:0] dstart_q;
	logic [FC_W-1:0]    ft_q;

	logic [WADDR_W-1:0] w_q;
	logic [WADDR_W-1:0] ws_q;
	logic [WADDR_W-1:0] wl_q;
	logic [BIT_W-1:0]   sb_q;
	logic               ph_first_q;
	logic               ph_last_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   found_q;
	logic [WORD_BITS-1:0] cur_q;
	logic [WORD_BITS-1:0] m_q;
	logic               pend_v_q;
	logic [CL_W-1:0]    pend_cl_q;
	logic [FC_W-1:0]    pend_fc_q;
	logic [BIT_W-1:0]   fbit_q;

	res_t res_q;
	logic strobe_q;

	// bitmap RAM
	logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
	logic [WORD_BITS-1:0] rdata_s1;
	logic [WADDR_W-1:0]   rd_addr;
	logic                 we;
	logic [WORD_BITS-1:0] wd;

	always_ff @(posedge clk) begin
		if (we) begin
			map_mem[w_q] <= wd;
		end
		rdata_s1 <= map_mem[rd_addr];
	end

	// request decode
	logic [TOT_W-1:0]   tot;
	logic [TOT_W-1:0]   tot_m1;
	logic [CL_W-1:0]    start_cl;
	logic               accept;
	logic               bad_count;
	logic               bad_hint;
	logic               no_space;
	logic [1:0]         rej_st;
	logic [WADDR_W-1:0] nw;
	logic               nw_last;
	logic [WORD_BITS-1:0] range_mask;
	logic [WORD_BITS-1:0] scan_m;
	logic [WORD_BITS-1:0] fmt_mask;
	logic [TOT_W-1:0]   rh;
	logic [TOT_W-1:0]   rh1;
	logic [TOT_W-1:0]   ft_fmt;
	logic [BIT_W-1:0]   pick_idx;
	logic [WORD_BITS-1:0] pick_bit;
	logic [WORD_BITS-1:0] m_clr;
	logic [CNT_W-1:0]   found_inc;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign res       = res_q;
	assign res_strobe = strobe_q;

	assign tot    = (total_q > TOT_W'(MAX_CLUSTERS)) ? TOT_W'(MAX_CLUSTERS) : total_q;
	assign tot_m1 = tot - TOT_W'(1);

	always_comb begin
		if (req.hint != '0) begin
			start_cl = req.hint;
		end else if ({1'b0, dstart_q} < tot) begin
			start_cl = CL_W'(dstart_q);
		end else begin
			start_cl = '0;
		end
	end

	assign bad_count = (req.count == '0) || (req.count > CNT_W'(MAX_BATCH));
	assign bad_hint  = (req.hint != '0) && ({1'b0, req.hint} >= tot);
	assign no_space  = ft_q < FC_W'(req.count);

	// status of an item answered at once
	assign rej_st = ((req.mode == MODE_ALLOC) && !bad_count && !bad_hint) ?
		ST_NOSPACE : ST_INVALID;

	assign nw      = (w_q == wl_q) ? '0 : w_q + WADDR_W'(1);
	assign nw_last = (nw == ws_q);

	// clusters of the current word that the search may visit
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			range_mask[b] = ({1'b0, w_q} < tot[TOT_W-1:BIT_W]) ||
				(({1'b0, w_q} == tot[TOT_W-1:BIT_W]) && (BIT_W'(b) < tot[BIT_W-1:0]));
			if (ph_first_q && (BIT_W'(b) < sb_q)) begin
				range_mask[b] = 1'b0;
			end
			if (ph_last_q && (BIT_W'(b) >= sb_q)) begin
				range_mask[b] = 1'b0;
			end
		end
	end

	assign scan_m = rdata_s1 & range_mask;

	// format: free below the total, reserve clusters 0 to rh
	assign rh     = TOT_W'(tot / PER_BLOCK) + TOT_W'((tot % PER_BLOCK) != 0);
	assign rh1    = rh + TOT_W'(1);
	assign ft_fmt = tot - ((rh1 < tot) ? rh1 : tot);

	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			fmt_mask[b] = ({1'b0, w_q, BIT_W'(b)} < tot) && ({1'b0, w_q, BIT_W'(b)} > rh);
		end
	end

	bca_ffs u_ffs (
		.vec (m_q),
		.idx (pick_idx)
	);

	assign pick_bit  = WORD_BITS'(1) << pick_idx;
	assign m_clr     = m_q & ~pick_bit;
	assign found_inc = found_q + CNT_W'(1);

	always_comb begin
		rd_addr = w_q;
		case (state_q)
			S_IDLE: begin
				if (req.mode == MODE_FREE) begin
					rd_addr = req.cluster_to_free[CL_W-1:BIT_W];
				end else begin
					rd_addr = start_cl[CL_W-1:BIT_W];
				end
			end
			S_SCAN:  rd_addr = nw;
			default: rd_addr = w_q;
		endcase
	end

	always_comb begin
		we = 1'b0;
		wd = cur_q;
		case (state_q)
			S_CLR: begin
				we = 1'b1;
				wd = '0;
			end
			S_FMT: begin
				we = 1'b1;
				wd = fmt_mask;
			end
			S_WB: begin
				we = 1'b1;
				wd = cur_q;
			end
			S_FREE: begin
				we = 1'b1;
				wd = rdata_s1 | (WORD_BITS'(1) << fbit_q);
			end
			default: begin
				we = 1'b0;
				wd = cur_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= TOT_W'(65536);
			dstart_q <= START_W'(6553);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TOTAL: total_q  <= cfg_data;
				CFG_START: dstart_q <= cfg_data[START_W-1:0];
				default: ;
			endcase
		end
	end

	// payload registers of the search
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ws_q       <= start_cl[CL_W-1:BIT_W];
				sb_q       <= start_cl[BIT_W-1:0];
				wl_q       <= tot_m1[CL_W-1:BIT_W];
				count_q    <= req.count;
				fbit_q     <= req.cluster_to_free[BIT_W-1:0];
			end
			S_SCAN: begin
				cur_q <= rdata_s1;
				m_q   <= scan_m;
			end
			S_PICK: begin
				cur_q     <= cur_q & ~pick_bit;
				m_q       <= m_clr;
				pend_cl_q <= {w_q, pick_idx};
				pend_fc_q <= (ft_q != '0) ? ft_q - FC_W'(1) : ft_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			w_q        <= '0;
			ft_q       <= '0;
			ph_first_q <= 1'b0;
			ph_last_q  <= 1'b0;
			found_q    <= '0;
			pend_v_q   <= 1'b0;
			strobe_q   <= 1'b0;
			res_q      <= '0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_CLR: begin
					w_q <= w_q + WADDR_W'(1);
					if (w_q == WADDR_W'(MAP_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						res_q    <= '{cluster: '0, status: rej_st, last: 1'b1,
							free_count: ft_q};
						found_q  <= '0;
						pend_v_q <= 1'b0;
						case (req.mode)
							MODE_ALLOC: begin
								if (bad_count || bad_hint || no_space || (tot == '0)) begin
									strobe_q <= 1'b1;
								end else begin
									w_q        <= start_cl[CL_W-1:BIT_W];
									ph_first_q <= 1'b1;
									ph_last_q  <= 1'b0;
									state_q    <= S_SCAN;
								end
							end
							MODE_FREE: begin
								if ({1'b0, req.cluster_to_free} >= tot) begin
									strobe_q <= 1'b1;
								end else begin
									w_q     <= req.cluster_to_free[CL_W-1:BIT_W];
									state_q <= S_FREE;
								end
							end
							MODE_FORMAT: begin
								w_q     <= '0;
								state_q <= S_FMT;
							end
							default: strobe_q <= 1'b1;
						endcase
					end
				end
				S_SCAN: begin
					if (scan_m != '0) begin
						state_q <= S_PICK;
					end else if (ph_last_q) begin
						state_q <= S_FIN;
					end else begin
						// nothing here: move on, read already issued
						w_q        <= nw;
						ph_first_q <= 1'b0;
						ph_last_q  <= nw_last;
					end
				end
				S_PICK: begin
					if (ft_q != '0) begin
						ft_q <= ft_q - FC_W'(1);
					end
					found_q <= found_inc;
					// emit the previous find: a later one exists, so it is not last
					if (pend_v_q) begin
						strobe_q <= 1'b1;
						res_q    <= '{cluster: pend_cl_q, status: ST_OK, last: 1'b0,
							free_count: pend_fc_q};
					end
					pend_v_q <= 1'b1;
					if ((found_inc == count_q) || (m_clr == '0)) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if ((found_q == count_q) || ph_last_q) begin
						state_q <= S_FIN;
					end else begin
						w_q        <= nw;
						ph_first_q <= 1'b0;
						ph_last_q  <= nw_last;
						state_q    <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_SCAN;
				end
				S_FIN: begin
					strobe_q <= 1'b1;
					if (pend_v_q) begin
						res_q <= '{cluster: pend_cl_q, status: ST_OK, last: 1'b1,
							free_count: pend_fc_q};
					end else begin
						res_q <= '{cluster: '0, status: ST_NOSPACE, last: 1'b1,
							free_count: ft_q};
					end
					pend_v_q <= 1'b0;
					state_q  <= S_IDLE;
				end
				S_FREE: begin
					strobe_q <= 1'b1;
					if (!rdata_s1[fbit_q] && (ft_q != '1)) begin
						ft_q  <= ft_q + FC_W'(1);
						res_q <= '{cluster: '0, status: ST_OK, last: 1'b1,
							free_count: ft_q + FC_W'(1)};
					end else begin
						res_q <= '{cluster: '0, status: ST_OK, last: 1'b1,
							free_count: ft_q};
					end
					state_q <= S_IDLE;
				end
				S_FMT: begin
					w_q <= w_q + WADDR_W'(1);
					if (w_q == WADDR_W'(MAP_WORDS - 1)) begin
						ft_q     <= FC_W'(ft_fmt);
						strobe_q <= 1'b1;
						res_q    <= '{cluster: '0, status: ST_OK, last: 1'b1,
							free_count: FC_W'(ft_fmt)};
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import bca_pkg::*;

	localparam int WATCHDOG_LIMIT = 8000;
	localparam int SETTLE_CYCLES  = 300;
	localparam int RESET_START    = 6553;

	localparam logic [1:0]           MODE_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	req_t                  req;
	logic                  res_strobe;
	res_t                  res;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Shadow of the allocator: free bitmap, free counter and registers
	bit                 free_bits [MAX_CLUSTERS];
	logic [FC_W-1:0]    free_cnt;
	logic [TOT_W-1:0]   cfg_total;
	logic [START_W-1:0] cfg_dflt;
	int unsigned        owned_clusters [$];
	res_t               expected_results [$];

	int errors       = 0;
	int mismatches   = 0;
	int items_sent   = 0;
	int results_seen = 0;
	int reg_writes   = 0;
	int idle_run     = 0;

	bitmap_cluster_allocator u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.res_strobe (res_strobe),
		.res        (res),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int unsigned eff_total();
		return (int'(cfg_total) > MAX_CLUSTERS) ? MAX_CLUSTERS : int'(cfg_total);
	endfunction

	function automatic void push_result(input int unsigned cl, input logic [1:0] st,
			input logic lst, input logic [FC_W-1:0] fc);
		res_t e;
		e.cluster    = CL_W'(cl);
		e.status     = st;
		e.last       = lst;
		e.free_count = fc;
		expected_results.insert(expected_results.size(), e);
	endfunction

	function automatic void predict_request(input req_t r);
		int unsigned tot;
		int unsigned pos;
		int unsigned c;
		int unsigned nfound;
		int unsigned resv;
		int unsigned taken;
		int unsigned got [MAX_BATCH];
		tot = eff_total();
		case (r.mode)
			MODE_ALLOC: begin
				if (r.count == 0 || r.count > MAX_BATCH) begin
					push_result(0, ST_INVALID, 1'b1, free_cnt);
				end else if (r.hint != 0 && r.hint >= tot) begin
					push_result(0, ST_INVALID, 1'b1, free_cnt);
				end else if (free_cnt < r.count) begin
					push_result(0, ST_NOSPACE, 1'b1, free_cnt);
				end else begin
					if (r.hint != 0)
						pos = r.hint;
					else
						pos = (cfg_dflt < tot) ? cfg_dflt : 0;
					nfound = 0;
					for (int unsigned i = 0; i < tot && nfound < r.count; i++) begin
						c = pos + i;
						if (c >= tot)
							c -= tot;
						if (free_bits[c]) begin
							free_bits[c] = 1'b0;
							got[nfound] = c;
							nfound++;
						end
					end
					if (nfound == 0) begin
						push_result(0, ST_NOSPACE, 1'b1, free_cnt);
					end else begin
						for (int unsigned k = 0; k < nfound; k++) begin
							if (free_cnt > 0)
								free_cnt--;
							push_result(got[k], ST_OK, k + 1 == nfound, free_cnt);
							owned_clusters.insert(owned_clusters.size(), got[k]);
						end
					end
				end
			end
			MODE_FREE: begin
				if (r.cluster_to_free >= tot) begin
					push_result(0, ST_INVALID, 1'b1, free_cnt);
				end else begin
					// a second free of the same cluster leaves the count alone
					if (!free_bits[r.cluster_to_free]) begin
						free_bits[r.cluster_to_free] = 1'b1;
						if (free_cnt < {FC_W{1'b1}})
							free_cnt++;
					end
					push_result(0, ST_OK, 1'b1, free_cnt);
				end
			end
			MODE_FORMAT: begin
				resv = tot / PER_BLOCK + ((tot % PER_BLOCK != 0) ? 1 : 0);
				foreach (free_bits[i])
					free_bits[i] = (i < tot);
				taken = 0;
				for (c = 0; c <= resv && c < tot; c++) begin
					free_bits[c] = 1'b0;
					taken++;
				end
				free_cnt = FC_W'(tot - taken);
				owned_clusters.delete();
				push_result(0, ST_OK, 1'b1, free_cnt);
			end
			default: begin
				push_result(0, ST_INVALID, 1'b1, free_cnt);
			end
		endcase
	endfunction

	function automatic req_t make_req(input logic [1:0] mode, input int unsigned hint,
			input int unsigned count, input int unsigned tofree);
		req_t r;
		r.mode            = mode;
		r.hint            = CL_W'(hint);
		r.count           = CNT_W'(count);
		r.cluster_to_free = CL_W'(tofree);
		return r;
	endfunction

	// Hold the item on the bus until the block takes it, then predict its results
	task automatic send_request(input req_t r);
		start     <= 1'b1;
		req       <= r;
		cfg_valid <= 1'b0;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		predict_request(r);
		items_sent++;
	endtask

	task automatic idle_for(input int n);
		start     <= 1'b0;
		cfg_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Drop start and wait until every expected result is in and the block is idle
	task automatic wait_quiet();
		start     <= 1'b0;
		cfg_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0 || busy !== 1'b0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		wait_quiet();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		case (idx)
			CFG_TOTAL: cfg_total = TOT_W'(val);
			CFG_START: cfg_dflt  = val[START_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic test_before_format();
		send_request(make_req(MODE_ALLOC, 0, 2, 0));
		send_request(make_req(MODE_FREE, 0, 1, 100));
		// the only free cluster lies below the default start: wrap to it
		send_request(make_req(MODE_ALLOC, 0, 1, 0));
		send_request(make_req(MODE_FREE, 0, 1, 65535));
	endtask

	task automatic test_format_and_alloc();
		send_request(make_req(MODE_FORMAT, 0, 1, 0));
		send_request(make_req(MODE_ALLOC, 65535, MAX_BATCH, 0));
		idle_for(13);
		send_request(make_req(MODE_ALLOC, 0, 1, 0));
		send_request(make_req(MODE_ALLOC, 0, 0, 0));
		send_request(make_req(MODE_ALLOC, 0, MAX_BATCH + 1, 0));
		send_request(make_req(MODE_ALLOC, 0, 127, 0));
		send_request(make_req(MODE_UNUSED, 16'hFFFF, 7'h7F, 16'hFFFF));
		send_request(make_req(MODE_FREE, 0, 1, RESET_START));
		send_request(make_req(MODE_FREE, 0, 1, RESET_START));
		// hand a reserved cluster back, then take it straight again
		send_request(make_req(MODE_FREE, 0, 1, 4));
		send_request(make_req(MODE_ALLOC, 4, 1, 0));
	endtask

	task automatic test_small_partition();
		write_reg(CFG_TOTAL, CFG_DATA_W'(64));
		write_reg(CFG_START, {CFG_DATA_W{1'b1}});
		write_reg(CFG_SPARE_A, CFG_DATA_W'($urandom()));
		write_reg(CFG_SPARE_B, CFG_DATA_W'($urandom()));
		send_request(make_req(MODE_FORMAT, 0, 1, 0));
		send_request(make_req(MODE_ALLOC, 0, 1, 0));
		send_request(make_req(MODE_ALLOC, 64, 1, 0));
		send_request(make_req(MODE_ALLOC, 65535, 1, 0));
		send_request(make_req(MODE_FREE, 0, 1, 64));
		send_request(make_req(MODE_FREE, 0, 1, 65535));
		send_request(make_req(MODE_ALLOC, 63, 61, 0));
		send_request(make_req(MODE_ALLOC, 0, 1, 0));
	endtask

	// Shrink the partition under a full count so the scan runs out early
	task automatic test_short_search();
		write_reg(CFG_TOTAL, {CFG_DATA_W{1'b1}});
		send_request(make_req(MODE_FORMAT, 0, 1, 0));
		write_reg(CFG_TOTAL, CFG_DATA_W'(64));
		write_reg(CFG_START, CFG_DATA_W'(10));
		send_request(make_req(MODE_ALLOC, 0, MAX_BATCH, 0));
		send_request(make_req(MODE_ALLOC, 0, 1, 0));
	endtask

	task automatic test_random_phase(input int unsigned total, input int unsigned dflt,
			input int n, input bit allow_idle);
		req_t        r;
		int unsigned tot;
		int          sel;
		int          pick;
		write_reg(CFG_TOTAL, CFG_DATA_W'(total));
		write_reg(CFG_START, CFG_DATA_W'(dflt));
		send_request(make_req(MODE_FORMAT, 0, 1, 0));
		tot = eff_total();
		for (int i = 0; i < n; i++) begin
			r.mode            = MODE_ALLOC;
			r.hint            = CL_W'($urandom());
			r.count           = CNT_W'($urandom());
			r.cluster_to_free = CL_W'($urandom());
			sel = $urandom_range(0, 99);
			if (sel < 50) begin
				pick = $urandom_range(0, 19);
				if (pick < 14)
					r.count = CNT_W'($urandom_range(1, 8));
				else if (pick < 18)
					r.count = CNT_W'($urandom_range(1, MAX_BATCH));
				else
					r.count = CNT_W'(MAX_BATCH);
				pick = $urandom_range(0, 9);
				if (pick < 4)
					r.hint = '0;
				else if (pick < 9)
					r.hint = CL_W'($urandom_range(1, tot - 1));
			end else if (sel < 85) begin
				r.mode = MODE_FREE;
				if (owned_clusters.size() != 0 && $urandom_range(0, 9) < 7) begin
					pick = $urandom_range(0, owned_clusters.size() - 1);
					r.cluster_to_free = CL_W'(owned_clusters[pick]);
					owned_clusters.delete(pick);
				end else if ($urandom_range(0, 1) == 0) begin
					r.cluster_to_free = CL_W'($urandom_range(0, tot - 1));
				end
			end else if (sel < 90) begin
				r.mode = MODE_FORMAT;
			end else if (sel < 95) begin
				r.count = ($urandom_range(0, 1) == 0) ? '0 : CNT_W'($urandom_range(65, 127));
			end else begin
				r.mode = MODE_UNUSED;
			end
			if (allow_idle && (i == n / 2 || $urandom_range(0, 11) == 0))
				wait_quiet();
			send_request(r);
			if (allow_idle && $urandom_range(0, 3) == 0)
				idle_for($urandom_range(1, 13));
		end
	endtask

	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && res_strobe) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: cluster %0d status %0d last %0d free %0d",
						res.cluster, res.status, res.last, res.free_count);
			end else begin
				want = expected_results.pop_front();
				if (res.cluster !== want.cluster || res.status !== want.status ||
						res.last !== want.last || res.free_count !== want.free_count) begin
					errors++;
					mismatches++;
					if (mismatches <= 10) begin
						$write("mismatch: expected cluster %0d status %0d last %0d free %0d,",
							want.cluster, want.status, want.last, want.free_count);
						$display(" got cluster %0d status %0d last %0d free %0d",
							res.cluster, res.status, res.last, res.free_count);
					end
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((start && !busy) || res_strobe || (cfg_valid && cfg_ready)) begin
			idle_run <= 0;
		end else if (idle_run >= WATCHDOG_LIMIT) begin
			$display("timeout: nothing moved for %0d cycles", WATCHDOG_LIMIT);
			$display("Some tests failed");
			$finish;
		end else begin
			idle_run <= idle_run + 1;
		end
	end

	initial begin : run
		arst_n    = 1'b0;
		start     = 1'b0;
		req       = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		free_cnt  = '0;
		cfg_total = TOT_W'(MAX_CLUSTERS);
		cfg_dflt  = START_W'(RESET_START);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_before_format();
		test_format_and_alloc();
		test_small_partition();
		test_short_search();
		test_random_phase(4096, $urandom_range(1, 4095), 60, 1'b1);
		test_random_phase(64, 65535, 45, 1'b1);
		test_random_phase(MAX_CLUSTERS, 0, 55, 1'b1);
		test_random_phase($urandom_range(64, 8192), $urandom_range(0, 65535), 50, 1'b1);
		test_random_phase($urandom_range(64, 2048), $urandom_range(0, 65535), 40, 1'b0);

		wait_quiet();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d requests, %0d results and %0d register writes:", items_sent,
			results_seen, reg_writes);
		$display("formats, wrapped next-fit scans, short searches, frees and rejected requests.");
		if (errors == 0 && expected_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// File: bitmap_cluster_allocator.f
src/bca_pkg.sv
src/bca_ffs.sv
src/bitmap_cluster_allocator.sv
verif/tb_top.sv
